/* src/wsdf_pkg.sv */
// ============================================================================
// wsdf_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ============================================================================
package wsdf_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 64;
    localparam int REM_W    = 63;
    localparam int KEY_W    = 32;
    localparam int OPCODE_W = 4;
    localparam int STATUS_W = 2;
    localparam int PHASE_W  = 3;
    localparam int LEFT_W   = 4;
    localparam int IDX_W    = 2;
    localparam int ODATA_W  = 16;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_HDR1   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HDR2   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTLEN = 3'd2;
    localparam logic [PHASE_W-1:0] PH_KEY    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOPBIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERSIZE = 2'd3;

    // 7-bit length codes that select an extended length
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    localparam logic [LEFT_W-1:0] LEN16_BYTES = 4'd2;
    localparam logic [LEFT_W-1:0] LEN64_BYTES = 4'd8;

    // Limit register reset: 1 GiB
    localparam logic [REM_W-1:0] MAX_LEN_RESET = 63'd1073741824;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic                fin;
        logic [OPCODE_W-1:0] opcode;
        logic                masked;
        logic                last;
    } wsdf_res_t;

endpackage

/* src/websocket_frame_deframer.sv */
// ============================================================================
// websocket_frame_deframer
// WebSocket frame parser: header, extended length, mask key, unmasked payload.
// ============================================================================
//
//  channel   dir  handshake                      content
//  s_axis    in   tvalid/tready                  tdata[7:0] raw stream byte
//  m_axis    out  tvalid/tready                  tdata payload + header fields,
//                                                tuser status, tlast end of frame
//  cfg       in   cfg_wr_en                      cfg_wr_data max payload length
//
//  One item per cycle sustained while m_axis is not stalled; each byte is
//  registered, parsed, and its result (if any) registered for m_axis.
//  Header, length and key bytes give no result item, except the byte that
//  completes the length or the key: it may carry a length error or an
//  empty-frame marker.
//  rst_n is asynchronous: parser returns to first header byte, limit to 1 GiB.
//  A stalled m_axis holds the result register; the input register then fills
//  and s_axis_tready drops until the result is taken.
// ============================================================================
module websocket_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    // tdata: data_byte[7:0]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: data_out[7:0], fin_flag[8], opcode[12:9], masked_flag[13], zero[15:14]
    output logic [15:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [62:0] cfg_wr_data
);
    import wsdf_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              can_take;
    logic              step;
    logic              res_valid;
    wsdf_res_t         res;

    // input byte moves into the parser when the result register has room
    assign step          = in_valid_reg && can_take;
    assign s_axis_tready = !in_valid_reg || can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    wsdf_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .byte_in     (in_byte_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsdf_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step && res_valid),
        .res_in        (res),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .can_take      (can_take)
    );

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a blocked result");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> m_axis_tvalid)
        else $error("parsed result not presented");

    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !step)
        else $error("parser advanced into a held result");

endmodule

/* src/wsdf_parser.sv */
// ============================================================================
// wsdf_parser
// Frame state and per-byte parse logic; one byte per step.
// ============================================================================
module wsdf_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [wsdf_pkg::REM_W-1:0]  cfg_wr_data,
    input  logic                        step,
    input  logic [wsdf_pkg::BYTE_W-1:0] byte_in,
    output logic                        res_valid,
    output wsdf_pkg::wsdf_res_t         res
);
    import wsdf_pkg::*;

    logic [REM_W-1:0]    max_len_reg;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                fin_reg, fin_next;
    logic [OPCODE_W-1:0] opcode_reg, opcode_next;
    logic                masked_reg, masked_next;
    logic [LEN_W-1:0]    accum_reg, accum_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic [LEN_W-1:0]    len_v;
    logic                len_top;
    logic                len_over;
    logic [BYTE_W-1:0]   key_byte;
    logic [REM_W-1:0]    rem_dec;

    // length candidate and its checks
    assign len_v    = (phase_reg == PH_HDR2) ? {57'd0, byte_in[6:0]}
                                             : {accum_reg[LEN_W-BYTE_W-1:0], byte_in};
    assign len_top  = len_v[LEN_W-1];
    assign len_over = (len_v[REM_W-1:0] > max_len_reg);
    assign rem_dec  = (rem_reg != '0) ? (rem_reg - 63'd1) : rem_reg;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb
    begin
        logic len_ready;
        len_ready   = 1'b0;
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        accum_next  = accum_reg;
        left_next   = left_reg;
        key_next    = key_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        res_valid   = 1'b0;
        res.status  = ST_PAYLOAD;
        res.data    = '0;
        res.last    = 1'b0;

        unique case (phase_reg)
            PH_HDR2:
            begin
                masked_next = byte_in[7];
                accum_next  = '0;
                if (byte_in[6:0] == LEN16_CODE)
                begin
                    left_next  = LEN16_BYTES;
                    phase_next = PH_EXTLEN;
                end
                else if (byte_in[6:0] == LEN64_CODE)
                begin
                    left_next  = LEN64_BYTES;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    left_next = '0;
                    len_ready = 1'b1;
                end
            end
            PH_EXTLEN:
            begin
                accum_next = len_v;
                if (left_reg != '0)
                    left_next = left_reg - 4'd1;
                len_ready = (left_next == '0);
            end
            PH_KEY:
            begin
                key_next = {key_reg[KEY_W-BYTE_W-1:0], byte_in};
                idx_next = idx_reg + 2'd1;
                if (idx_next == '0)
                begin
                    if (rem_reg == '0)
                    begin
                        phase_next = PH_HDR1;
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                        res.last   = 1'b1;
                    end
                    else
                        phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                res.data  = masked_reg ? (byte_in ^ key_byte) : byte_in;
                idx_next  = idx_reg + 2'd1;
                rem_next  = rem_dec;
                res.last  = (rem_dec == '0);
                if (rem_dec == '0)
                    phase_next = PH_HDR1;
            end
            default:
            begin
                // first header byte; spare phase codes land here too
                fin_next    = byte_in[7];
                opcode_next = byte_in[3:0];
                phase_next  = PH_HDR2;
            end
        endcase

        if (len_ready)
        begin
            priority if (len_top)
            begin
                phase_next = PH_HDR1;
                res_valid  = 1'b1;
                res.status = ST_TOPBIT;
                res.last   = 1'b1;
            end
            else if (len_over)
            begin
                phase_next = PH_HDR1;
                res_valid  = 1'b1;
                res.status = ST_OVERSIZE;
                res.last   = 1'b1;
            end
            else
            begin
                rem_next = len_v[REM_W-1:0];
                idx_next = '0;
                if (masked_next)
                begin
                    phase_next = PH_KEY;
                    key_next   = '0;
                end
                else if (len_v[REM_W-1:0] == '0)
                begin
                    phase_next = PH_HDR1;
                    res_valid  = 1'b1;
                    res.status = ST_EMPTY;
                    res.last   = 1'b1;
                end
                else
                    phase_next = PH_DATA;
            end
        end

        res.fin    = fin_next;
        res.opcode = opcode_next;
        res.masked = masked_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg_wr_en)
            max_len_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR1;
            fin_reg    <= 1'b0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            accum_reg  <= '0;
            left_reg   <= '0;
            key_reg    <= '0;
            rem_reg    <= '0;
            idx_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            fin_reg    <= fin_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            accum_reg  <= accum_next;
            left_reg   <= left_next;
            key_reg    <= key_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
        end
    end

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (rem_reg != '0))
        else $error("payload phase with no bytes left");

    a_extlen_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_EXTLEN) |-> (left_reg != '0))
        else $error("extended length phase with zero count");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != ST_PAYLOAD) |-> (res.last && res.data == '0))
        else $error("marker or error result malformed");

endmodule

/* src/wsdf_out_reg.sv */
// ============================================================================
// wsdf_out_reg
// Result register driving the master-side stream.
// ============================================================================
module wsdf_out_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  wsdf_pkg::wsdf_res_t          res_in,
    input  logic                         m_axis_tready,
    output logic                         m_axis_tvalid,
    output logic [wsdf_pkg::ODATA_W-1:0] m_axis_tdata,
    output logic [wsdf_pkg::STATUS_W-1:0] m_axis_tuser,
    output logic                         m_axis_tlast,
    output logic                         can_take
);
    import wsdf_pkg::*;

    logic      valid_reg;
    wsdf_res_t res_reg;

    assign can_take = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_take)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (can_take && load)
            res_reg <= res_in;
    end

    assign m_axis_tvalid = valid_reg;
    // tdata: data_out[7:0], fin_flag[8], opcode[12:9], masked_flag[13], zero[15:14]
    assign m_axis_tdata  = {2'b00, res_reg.masked, res_reg.opcode, res_reg.fin, res_reg.data};
    assign m_axis_tuser  = res_reg.status;
    assign m_axis_tlast  = res_reg.last;

endmodule

/* bench/tb.sv */
// ============================================================================
// tb - WebSocket frame deframer testbench
// Streams WebSocket frames into the deframer one byte per item and checks
// every result item against an in-bench model of the parser. Directed cases
// cover header and length forms, masking, empty frames, both length errors
// and the edges of the payload limit. Randomised traffic follows, with idle
// bursts on both sides and several limit settings, after a directed long sink hold-off.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsdf_pkg::*;

    localparam int CLK_HALF     = 10;    // 20 ns period
    localparam int DRAIN_CYCLES = 4;     // two-stage pipe plus margin
    localparam int HOLD_CYCLES  = 150;   // long sink hold-off
    localparam int STALL_LIMIT  = 1000;  // cycles with no handshake at all
    localparam int ITEMS_TARGET = 1350;  // total bytes offered
    localparam int PHASE_ITEMS  = 170;   // bytes per limit setting

    // How the frame length is carried in the header
    typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // data_byte[7:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // data_out[7:0], fin_flag[8], opcode[12:9], masked_flag[13], zero[15:14]
    logic [15:0]         m_axis_tdata;
    logic [1:0]          m_axis_tuser;   // status[1:0]
    logic                m_axis_tlast;
    logic                cfg_wr_en;
    logic [REM_W-1:0]    cfg_wr_data;

    // Bench control
    bit                  gaps_on = 1'b1; // random idle bursts on both sides
    bit                  hold_req = 1'b0; // ask the sink for one long hold-off
    int                  items_sent = 0;
    int                  mismatches = 0;
    int                  idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Parser model state, reset values as after rst_n
    // ------------------------------------------------------------------------
    wsdf_res_t           deframed_q[$];  // expected result items, oldest first
    logic [PHASE_W-1:0]  p_phase     = PH_HDR1;
    logic                p_fin       = 1'b0;
    logic [OPCODE_W-1:0] p_opcode    = '0;
    logic                p_masked    = 1'b0;
    logic [LEN_W-1:0]    p_len       = '0;
    logic [LEFT_W-1:0]   p_len_left  = '0;
    logic [KEY_W-1:0]    p_key       = '0;
    logic [REM_W-1:0]    p_remaining = '0;
    logic [IDX_W-1:0]    p_key_pos   = '0;
    logic [REM_W-1:0]    len_limit   = MAX_LEN_RESET;

    always #CLK_HALF clk = ~clk;

    websocket_frame_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Every result carries the header fields of the frame in progress
    function automatic void push_result(logic [STATUS_W-1:0] st, logic [BYTE_W-1:0] d,
                                        logic last);
        wsdf_res_t r;
        r.status = st;
        r.data   = d;
        r.fin    = p_fin;
        r.opcode = p_opcode;
        r.masked = p_masked;
        r.last   = last;
        deframed_q.push_back(r);
    endfunction

    // Length and key known: empty frame gives its marker straight away
    function automatic void open_payload();
        p_key_pos = '0;
        if (p_remaining == '0)
        begin
            p_phase = PH_HDR1;
            push_result(ST_EMPTY, '0, 1'b1);
        end
        else
        begin
            p_phase = PH_DATA;
        end
    endfunction

    // Top bit is tested first, so it wins over the limit
    function automatic void close_length(logic [LEN_W-1:0] len);
        if (len[LEN_W-1])
        begin
            p_phase = PH_HDR1;
            push_result(ST_TOPBIT, '0, 1'b1);
        end
        else if (len[REM_W-1:0] > len_limit)
        begin
            p_phase = PH_HDR1;
            push_result(ST_OVERSIZE, '0, 1'b1);
        end
        else
        begin
            p_remaining = len[REM_W-1:0];
            if (p_masked)
            begin
                p_phase   = PH_KEY;
                p_key_pos = '0;
                p_key     = '0;
            end
            else
            begin
                open_payload();
            end
        end
    endfunction

    // One accepted stream byte through the parser
    function automatic void deframe_byte(logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        case (p_phase)
            PH_HDR2:
            begin
                p_masked = b[7];
                p_len    = '0;
                if (b[6:0] == LEN16_CODE)
                begin
                    p_len_left = LEN16_BYTES;
                    p_phase    = PH_EXTLEN;
                end
                else if (b[6:0] == LEN64_CODE)
                begin
                    p_len_left = LEN64_BYTES;
                    p_phase    = PH_EXTLEN;
                end
                else
                begin
                    p_len_left = '0;
                    close_length(LEN_W'(b[6:0]));
                end
            end
            PH_EXTLEN:
            begin
                // big-endian: shift earlier bytes up
                p_len = {p_len[LEN_W-9:0], b};
                if (p_len_left != '0)
                    p_len_left = p_len_left - 1'b1;
                if (p_len_left == '0)
                    close_length(p_len);
            end
            PH_KEY:
            begin
                // first key byte ends up in the top byte
                p_key     = {p_key[KEY_W-9:0], b};
                p_key_pos = p_key_pos + 1'b1;
                if (p_key_pos == '0)
                    open_payload();
            end
            PH_DATA:
            begin
                d = b;
                if (p_masked)
                    d = d ^ p_key[8*(3-p_key_pos) +: 8];
                p_key_pos = p_key_pos + 1'b1;
                if (p_remaining != '0)
                    p_remaining = p_remaining - 1'b1;
                if (p_remaining == '0)
                    p_phase = PH_HDR1;
                push_result(ST_PAYLOAD, d, p_remaining == '0);
            end
            default:
            begin
                // RSV bits [6:4] are ignored
                p_fin    = b[7];
                p_opcode = b[3:0];
                p_phase  = PH_HDR2;
            end
        endcase
    endfunction

    // True when a frame of this length would be taken rather than rejected
    function automatic bit length_fits(logic [LEN_W-1:0] len);
        return !len[LEN_W-1] && (len[REM_W-1:0] <= len_limit);
    endfunction

    // ------------------------------------------------------------------------
    // Source side. All tasks start and end at a falling edge.
    // ------------------------------------------------------------------------

    // Offer one byte, hold until taken, then run it through the model
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        deframe_byte(b);
        items_sent++;
        @(negedge clk);
    endtask

    // Header, length in the chosen form, then whatever key and payload the
    // parser now expects (none if the length is rejected)
    task automatic send_frame(input logic [BYTE_W-1:0] hdr, input logic masked,
                              input len_form_t form, input logic [LEN_W-1:0] len);
        send_byte(hdr);
        case (form)
            LEN_EXT16:
            begin
                send_byte({masked, LEN16_CODE});
                for (int i = 1; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            LEN_EXT64:
            begin
                send_byte({masked, LEN64_CODE});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
            default:
                send_byte({masked, len[6:0]});
        endcase
        while (p_phase == PH_KEY || p_phase == PH_DATA)
            send_byte(BYTE_W'($urandom));
    endtask

    // All results in, and any header byte still in the pipe has gone through
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        wait (deframed_q.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [REM_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        len_limit = value;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Short lengths, RSV bits set, masked payload wrapping the key, and an
    // empty masked frame whose marker only comes after the key bytes
    task automatic test_basic_frames();
        send_frame(8'h70, 1'b0, LEN_SHORT, 0);
        send_frame(8'hFF, 1'b0, LEN_SHORT, 1);
        send_frame(8'h0A, 1'b1, LEN_SHORT, 5);
        send_frame(8'h89, 1'b1, LEN_SHORT, 0);
    endtask

    // Both length errors at the reset limit; parsing restarts at the header
    task automatic test_length_errors();
        send_frame(8'h81, 1'b0, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(8'h02, 1'b1, LEN_EXT64, 64'h0000_0000_4000_0001);
    endtask

    // Sink stalls for a long stretch from the start of the frame; the source keeps offering
    // until the block backs up and drops tready
    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        send_frame(8'h82, 1'b1, LEN_SHORT, 48);
        wait_idle();
        gaps_on = 1'b1;
    endtask

    // Limit at zero, at a small value (equal accepted, one over rejected)
    // and at its maximum
    task automatic test_limit_edges();
        write_limit('0);
        send_frame(8'h81, 1'b0, LEN_SHORT, 0);
        send_frame(8'h81, 1'b1, LEN_SHORT, 1);
        send_frame(8'h01, 1'b0, LEN_EXT64, 64'h8000_0000_0000_0000);
        write_limit(5);
        send_frame(8'h82, 1'b1, LEN_EXT64, 5);
        send_frame(8'h82, 1'b0, LEN_EXT16, 6);
        send_frame(8'h88, 1'b0, LEN_EXT16, 0);
        write_limit('1);
        send_frame(8'h09, 1'b0, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(8'h8F, 1'b1, LEN_EXT16, 3);
    endtask

    // Mostly well-formed frames with random content under a rotating limit,
    // plus raw noise while the limit keeps any accepted length short
    task automatic test_random_traffic();
        int          phase_no;
        int          phase_start;
        int unsigned pick;
        logic [7:0]  hdr;
        logic        masked;
        logic [63:0] len;
        logic [63:0] rnd;
        len_form_t   form;
        phase_no = 0;
        while (items_sent < ITEMS_TARGET)
        begin
            rnd = {$urandom, $urandom};
            case (phase_no % 4)
                0:       write_limit(REM_W'($urandom_range(0, 40)));
                1:       write_limit('1);
                2:       write_limit(MAX_LEN_RESET);
                default: write_limit(rnd[REM_W-1:0]);
            endcase
            phase_no++;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEMS_TARGET)
            begin
                // the tail of the run goes flat out on both sides
                gaps_on = (items_sent < ITEMS_TARGET - 200);
                hdr    = 8'($urandom);
                masked = 1'($urandom);
                pick   = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    len  = 64'($urandom_range(0, 12));
                    form = LEN_SHORT;
                    if ($urandom_range(0, 3) == 0)
                        form = $urandom_range(0, 1) ? LEN_EXT16 : LEN_EXT64;
                    send_frame(hdr, masked, form, len);
                end
                else if (pick < 65)
                begin
                    len = 64'($urandom_range(13, 125));
                    send_frame(hdr, masked, LEN_SHORT, len);
                end
                else if (pick < 78)
                begin
                    // big 16-bit lengths only where they are rejected
                    len = 64'($urandom_range(0, 65535));
                    if (length_fits(len) && len > 300)
                        len = 64'(len[5:0]);
                    send_frame(hdr, masked, LEN_EXT16, len);
                end
                else if (pick < 90 || len_limit > 125)
                begin
                    len = {$urandom, $urandom};
                    if (length_fits(len))
                        len = 64'(len[5:0]);
                    send_frame(hdr, masked, LEN_EXT64, len);
                end
                else
                begin
                    // noise, then bytes until the parser is back at a header
                    repeat ($urandom_range(1, 6))
                        send_byte(BYTE_W'($urandom));
                    while (p_phase != PH_HDR1)
                        send_byte(BYTE_W'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sink side: ready driven at the falling edge, random low bursts while gaps
    // are on, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : sink_ready
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check at the rising edge, plus the no-handshake cycle count
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        wsdf_res_t got;
        wsdf_res_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;

            if (m_axis_tvalid === 1'b1 && m_axis_tready)
            begin
                got.status = m_axis_tuser;
                got.data   = m_axis_tdata[7:0];
                got.fin    = m_axis_tdata[8];
                got.opcode = m_axis_tdata[12:9];
                got.masked = m_axis_tdata[13];
                got.last   = m_axis_tlast;
                if (deframed_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d data=%02h last=%0b",
                             $realtime, got.status, got.data, got.last);
                    mismatches++;
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (got !== want || m_axis_tdata[15:14] !== 2'b00)
                    begin
                        $display({"%0t: mismatch exp status=%0d data=%02h fin=%0b",
                                  " op=%0h msk=%0b last=%0b pad=0"},
                                 $realtime, want.status, want.data, want.fin,
                                 want.opcode, want.masked, want.last);
                        $display({"%0t:          got status=%0d data=%02h fin=%0b",
                                  " op=%0h msk=%0b last=%0b pad=%0d"},
                                 $realtime, got.status, got.data, got.fin,
                                 got.opcode, got.masked, got.last,
                                 m_axis_tdata[15:14]);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Nothing moving on either side for too long: the block has hung
    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $realtime, STALL_LIMIT, deframed_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_basic_frames();
        test_length_errors();
        test_backpressure();
        test_limit_edges();
        test_random_traffic();

        // drain, then allow for anything stray coming out late
        s_axis_tvalid <= 1'b0;
        wait (deframed_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
